// File: design/oai_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the ordered array block.
// No dependencies; imported by the cell, the top level, the checker and the bench.
package oai_pkg;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   // Update command broadcast to every cell in the row.
   typedef struct packed {
      logic             append;
      logic             insert;
      logic             erase;
      logic             write;
      logic [POS_W-1:0] pos;
   } cmd_type;

endpackage

// File: design/oai_cell.sv
`timescale 1ns / 1ps
// One storage cell of the ordered array row: holds one word and picks
// its next value from itself, its neighbors or the incoming word. Uses oai_pkg.
module oai_cell
   import oai_pkg::*;
#(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic              clock,
   input  cmd_type           cmd,
   input  logic [CW-1:0]     count,
   input  logic [DATA_W-1:0] value,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data
);

   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW:0] IDX_C  = (CMPW+1)'(IDX);

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic [CMPW:0]     pos_ext;
   logic [CMPW:0]     cnt_ext;

   assign pos_ext = (CMPW+1)'(cmd.pos);
   assign cnt_ext = (CMPW+1)'(count);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.append && IDX_C == cnt_ext) begin
         entry_in = value;
      end else if (cmd.insert && IDX_C == pos_ext) begin
         entry_in = value;
      end else if (cmd.insert && IDX_C > pos_ext && IDX_C <= cnt_ext) begin
         entry_in = left_data;
      end else if (cmd.erase && IDX_C >= pos_ext && (IDX_C + 1'b1) < cnt_ext) begin
         entry_in = right_data;
      end else if (cmd.write && IDX_C == pos_ext) begin
         entry_in = value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;

endmodule

// File: design/ordered_array_insert_erase.sv
`timescale 1ns / 1ps
// Ordered array with insert and erase by shifting. A transaction's result is
// registered and available the cycle after the transaction is taken; the
// block takes a new transaction every cycle while the result register is free
// or being drained, since the whole row of cells shifts in parallel. The input
// stalls only while a result is held by a stalled output.
// Storage is not cleared at reset; only the fill count and result valid flag are.
// Top level: decode, fill count, result register. Depends on oai_pkg, oai_cell.
module ordered_array_insert_erase
   import oai_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic [COUNT_W-1:0]  rsp_count
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [DATA_W-1:0]   rdata_ff;
   logic [COUNT_W-1:0]  rcount_ff;

   logic                accept;
   cmd_type             cmd;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   rdata;
   logic [CMPW-1:0]     pos_ext;
   logic [CMPW-1:0]     cnt_ext;
   logic                full;
   logic [DATA_W-1:0]   cell_data [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign pos_ext   = CMPW'(req_position);
   assign cnt_ext   = CMPW'(count_ff);
   assign full      = (cnt_ext == DEPTH_C);

   always_comb begin
      cmd        = '0;
      cmd.pos    = req_position;
      status     = STATUS_OK;
      rdata      = '0;
      case (req_kind)
         KIND_APPEND: begin
            if (full) status = STATUS_FULL;
            else      cmd.append = accept;
         end
         KIND_INSERT: begin
            if (pos_ext > cnt_ext) status = STATUS_BADPOS;
            else if (full)         status = STATUS_FULL;
            else                   cmd.insert = accept;
         end
         KIND_ERASE: begin
            if (pos_ext >= cnt_ext) status = STATUS_BADPOS;
            else                    cmd.erase = accept;
         end
         KIND_READ: begin
            if (pos_ext >= cnt_ext) status = STATUS_BADPOS;
            else                    rdata = cell_data[IW'(req_position)];
         end
         KIND_WRITE: begin
            if (pos_ext >= cnt_ext) status = STATUS_BADPOS;
            else                    cmd.write = accept;
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append || cmd.insert) count_in = count_ff + 1'b1;
      else if (cmd.erase)           count_in = count_ff - 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)          rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [DATA_W-1:0] left_w;
         logic [DATA_W-1:0] right_w;
         if (gi == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_left
            assign left_w = cell_data[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_right
            assign right_w = cell_data[gi+1];
         end
         oai_cell #(
            .IDX (gi),
            .CW  (CW)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .value      (req_value),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded per accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status;
         rdata_ff  <= rdata;
         rcount_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_value = rdata_ff;
   assign rsp_count      = rcount_ff;

endmodule

// File: design/oai_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ordered array block, bound to the top level.
// Depends on oai_pkg.
module oai_checker
   import oai_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [KIND_W-1:0]   req_kind,
   input logic [POS_W-1:0]    req_position,
   input logic [DATA_W-1:0]   req_value,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [DATA_W-1:0]   rsp_read_value,
   input logic [COUNT_W-1:0]  rsp_count
);

   // every accepted transaction shows a result on the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("result missing after accepted transaction");

   // input is held back only by a stalled pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a pending result");

   // failed operations return no data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_read_value == '0)
      else $error("read data on failed transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_count))
      else $error("stalled result changed");

   // a stalled request keeps its payload until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_kind)
         && $stable(req_position) && $stable(req_value))
      else $error("stalled request changed");

endmodule

bind ordered_array_insert_erase oai_checker u_oai_checker (.*);

// File: tb/tb_ordered_array_insert_erase.sv
`timescale 1ns / 1ps
// Self-checking bench for ordered_array_insert_erase: directed and random transactions
// checked against an array image kept in the bench. Depends on oai_pkg and the block RTL.
module tb_ordered_array_insert_erase
   import oai_pkg::*;
;

   localparam int DEPTH      = 16;
   localparam int CLK_HALF   = 2;
   localparam int RESET_CYC  = 5;
   localparam int RANDOM_OPS = 880;
   localparam int CALM_TAIL  = 100;
   localparam int LONG_HOLD  = 60;
   localparam int HOLD_AT    = 300;
   localparam int SETTLE     = 8;
   localparam int TIMEOUT_NS = 1_000_000;
   localparam logic [KIND_W-1:0] KIND_LAST = '1;
   localparam logic [POS_W-1:0]  POS_LAST  = '1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] value;
   } op_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_value;
      logic [COUNT_W-1:0]  count;
   } op_result_type;

   typedef struct packed {
      logic [DEPTH-1:0][DATA_W-1:0] words;
      logic [COUNT_W-1:0]           count;
   } array_image_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind       = '0;
   logic [POS_W-1:0]    req_position   = '0;
   logic [DATA_W-1:0]   req_value      = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [DATA_W-1:0]   rsp_read_value;
   logic [COUNT_W-1:0]  rsp_count;

   op_item_type     pending_ops[$];
   op_result_type   expected_results[$];
   array_image_type gen_image;
   array_image_type dut_image;

   int  ops_total     = 0;
   int  ops_accepted  = 0;
   int  results_seen  = 0;
   int  mismatches    = 0;
   int  n_ok          = 0;
   int  n_badpos      = 0;
   int  n_full        = 0;
   int  n_capacity    = 0;
   int  n_drained     = 0;
   int  last_count    = 0;
   bit  req_fired     = 1'b0;
   int  send_gap      = 0;
   int  stall_left    = 0;
   int  hold_left     = 0;
   bit  long_hold_done = 1'b0;
   logic calm;

   // no idling in a window mid-run and in the tail
   assign calm = (ops_accepted >= 500 && ops_accepted < 600) ||
                 (ops_accepted + CALM_TAIL >= ops_total);

   ordered_array_insert_erase #(.DEPTH(DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_count      (rsp_count)
   );

   always #(CLK_HALF) clock = ~clock;

   // Applies one transaction to an array image and returns its result.
   function automatic op_result_type apply_op(inout array_image_type img,
                                              input op_item_type op);
      op_result_type res;
      int cnt;
      int pos;
      int i;
      res.status     = STATUS_OK;
      res.read_value = '0;
      cnt = int'(img.count);
      pos = int'(op.position);
      case (op.kind)
         KIND_APPEND: begin
            if (cnt >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               img.words[cnt] = op.value;
               img.count = COUNT_W'(cnt + 1);
            end
         end
         KIND_INSERT: begin
            // position check wins over the full check
            if (pos > cnt) begin
               res.status = STATUS_BADPOS;
            end else if (cnt >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = cnt; i > pos; i--) img.words[i] = img.words[i-1];
               img.words[pos] = op.value;
               img.count = COUNT_W'(cnt + 1);
            end
         end
         KIND_ERASE: begin
            if (pos >= cnt) begin
               res.status = STATUS_BADPOS;
            end else begin
               for (i = pos; i + 1 < cnt; i++) img.words[i] = img.words[i+1];
               img.count = COUNT_W'(cnt - 1);
            end
         end
         KIND_READ: begin
            if (pos >= cnt) res.status = STATUS_BADPOS;
            else res.read_value = img.words[pos];
         end
         KIND_WRITE: begin
            if (pos >= cnt) res.status = STATUS_BADPOS;
            else img.words[pos] = op.value;
         end
         default: ;
      endcase
      res.count = img.count;
      return res;
   endfunction

   task automatic queue_op(input logic [KIND_W-1:0] kind, input int pos,
                           input logic [DATA_W-1:0] value);
      op_item_type op;
      op.kind     = kind;
      op.position = POS_W'(pos);
      op.value    = value;
      pending_ops.insert(pending_ops.size(), op);
      void'(apply_op(gen_image, op));
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Driver: a valid transaction is held until accepted, gaps only between transactions.
   always @(negedge clock) begin : drive_req
      op_item_type nxt;
      bit          go;
      go = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_ops.size() > 0) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = int'($urandom_range(1, 10)) - 1;
            end else begin
               nxt = pending_ops.pop_front();
               go  = 1'b1;
            end
         end
         req_valid <= go;
         if (go) begin
            req_kind     <= nxt.kind;
            req_position <= nxt.position;
            req_value    <= nxt.value;
         end else begin
            // junk payload while idle
            req_kind     <= KIND_W'($urandom);
            req_position <= POS_W'($urandom);
            req_value    <= $urandom;
         end
      end
   end

   // Receiver: short random stall bursts plus one long hold to back up the input.
   always @(negedge clock) begin : drive_rsp
      bit stall;
      stall = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         stall = 1'b1;
      end else if (!long_hold_done && ops_accepted >= HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         stall = 1'b1;
      end else if (!reset && !calm && $urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(1, 10)) - 1;
         stall = 1'b1;
      end
      rsp_stall <= stall;
   end

   // Monitor: predict on input acceptance, check on result acceptance.
   always @(posedge clock) begin : monitor
      op_item_type   taken;
      op_result_type want;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_valid && !req_stall;
         if (req_fired) begin
            taken.kind     = req_kind;
            taken.position = req_position;
            taken.value    = req_value;
            want = apply_op(dut_image, taken);
            expected_results.insert(expected_results.size(), want);
            ops_accepted++;
            case (want.status)
               STATUS_OK:     n_ok++;
               STATUS_BADPOS: n_badpos++;
               default:       n_full++;
            endcase
            if (int'(want.count) == DEPTH && last_count != DEPTH) n_capacity++;
            if (want.count == '0 && last_count != 0) n_drained++;
            last_count = int'(want.count);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = expected_results.pop_front();
               results_seen++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            results_seen, rsp_status, want.status));
               if (rsp_read_value !== want.read_value)
                  report_mismatch($sformatf("result %0d read_value %h, want %h",
                                            results_seen, rsp_read_value, want.read_value));
               if (rsp_count !== want.count)
                  report_mismatch($sformatf("result %0d count %0d, want %0d",
                                            results_seen, rsp_count, want.count));
            end
         end
      end
   end

   initial begin : main
      int cnt;
      int roll;
      int pos;
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  value;
      bit growing;

      gen_image = '0;
      dut_image = '0;

      // empty array: every indexed access is out of range
      queue_op(KIND_READ,   0, 32'h0);
      queue_op(KIND_ERASE,  0, 32'h0);
      queue_op(KIND_WRITE,  0, 32'h1111_1111);
      queue_op(KIND_INSERT, 1, 32'h2222_2222);
      queue_op(KIND_APPEND, 0, 32'hFFFF_FFFF);
      queue_op(KIND_INSERT, 0, 32'h0000_0000);
      queue_op(KIND_INSERT, 2, 32'hA5A5_A5A5);
      queue_op(KIND_INSERT, 1, 32'h5A5A_5A5A);
      queue_op(KIND_READ,   0, 32'h0);
      queue_op(KIND_READ,   3, 32'h0);
      queue_op(KIND_READ,   4, 32'h0);
      queue_op(KIND_READ,   int'(POS_LAST), 32'hFFFF_FFFF);
      queue_op(KIND_WRITE,  2, 32'h1234_5678);
      queue_op(KIND_READ,   2, 32'h0);
      queue_op(KIND_ERASE,  1, 32'h0);
      queue_op(KIND_ERASE,  2, 32'h0);
      queue_op(KIND_READ,   1, 32'h0);
      queue_op(KIND_WRITE,  5, 32'h0);
      queue_op(KIND_ERASE,  5, 32'h0);
      queue_op(KIND_INSERT, int'(POS_LAST), 32'h0);
      queue_op(KIND_WRITE + 3'd1, 0, 32'hDEAD_BEEF);
      queue_op(KIND_WRITE + 3'd2, 1, 32'h0);
      queue_op(KIND_LAST, int'(POS_LAST), 32'hFFFF_FFFF);
      queue_op(KIND_APPEND, 0, 32'h0);

      // random: alternate growing toward full and shrinking toward empty
      growing = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         cnt = int'(gen_image.count);
         if (cnt == DEPTH) growing = 1'b0;
         else if (cnt == 0) growing = 1'b1;
         roll = int'($urandom_range(0, 99));
         if (roll < 5)
            kind = KIND_W'($urandom_range(int'(KIND_WRITE) + 1, int'(KIND_LAST)));
         else if (growing)
            kind = (roll < 35) ? KIND_APPEND : (roll < 60) ? KIND_INSERT :
                   (roll < 70) ? KIND_ERASE  : (roll < 85) ? KIND_READ : KIND_WRITE;
         else
            kind = (roll < 12) ? KIND_APPEND : (roll < 22) ? KIND_INSERT :
                   (roll < 60) ? KIND_ERASE  : (roll < 80) ? KIND_READ : KIND_WRITE;
         if ($urandom_range(0, 9) == 0)
            pos = int'($urandom_range(0, int'(POS_LAST)));
         else if (kind == KIND_INSERT)
            pos = int'($urandom_range(0, cnt));
         else if (cnt > 0)
            pos = int'($urandom_range(0, cnt - 1));
         else
            pos = 0;
         roll = int'($urandom_range(0, 7));
         value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
         queue_op(kind, pos, value);
      end
      ops_total = pending_ops.size();

      repeat (RESET_CYC) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (ops_accepted < ops_total || expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("Covered %0d transactions (%0d ok, %0d bad position, %0d full),",
               ops_accepted, n_ok, n_badpos, n_full);
      $display("%0d results checked; array filled to capacity %0d times, drained %0d times.",
               results_seen, n_capacity, n_drained);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches.", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timeout: %0d of %0d transactions accepted, %0d results pending.",
               ops_accepted, ops_total, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
design/oai_pkg.sv
design/oai_cell.sv
design/ordered_array_insert_erase.sv
design/oai_checker.sv
tb/tb_ordered_array_insert_erase.sv
